// ===== rtl/tclf_pkg.sv =====
`timescale 1ns / 1ps

package tclf_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int LIM_W = 4;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 4'd5;

  typedef enum logic [1:0] {
    ENT_CLOSED      = 2'd0,
    ENT_SYN_WAIT    = 2'd1,
    ENT_ESTABLISHED = 2'd2,
    ENT_FIN_WAIT    = 2'd3
  } ent_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_OPENED      = 3'd1,
    EV_ESTABLISHED = 3'd2,
    EV_FIN         = 3'd3,
    EV_CLOSED      = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    OP_PASS  = 3'd0,
    OP_OPEN  = 3'd1,
    OP_ESTAB = 3'd2,
    OP_FIN   = 3'd3,
    OP_OTHER = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_MATCH  = 2'd1,
    S_COMMIT = 2'd2
  } st_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
  } req_t;

  typedef struct packed {
    logic             claimed;
    logic [IDX_W-1:0] slot;
    logic             closing;
  } chain_t;

endpackage

// ===== rtl/tclf_cell.sv =====
`timescale 1ns / 1ps

module tclf_cell
  import tclf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx,
  input  req_t             req,
  input  logic             match_en,
  input  logic             commit_en,
  input  logic             open_ok,
  input  chain_t           chain_in,
  output chain_t           chain_out,
  output logic             open_o
);

  ent_t        state_r, state_nxt;
  logic [31:0] addr_r;
  logic [15:0] port_r;
  logic [31:0] seq_r;

  logic hit_closed_r, hit_syn_r, hit_est_r, hit_fw_r, hit_any_r;
  logic src_eq, dst_eq, hit, take;

  assign src_eq = (addr_r == req.src_ip) && (port_r == req.src_port);
  assign dst_eq = (addr_r == req.dst_ip) && (port_r == req.dst_port);

  always_ff @(posedge clk) begin
    if (match_en) begin
      hit_closed_r <= (state_r == ENT_CLOSED);
      hit_syn_r    <= (state_r == ENT_SYN_WAIT) && (req.ack_num == seq_r + 32'd1);
      hit_est_r    <= (state_r == ENT_ESTABLISHED) && dst_eq;
      hit_fw_r     <= (state_r == ENT_FIN_WAIT) && src_eq;
      hit_any_r    <= (state_r != ENT_CLOSED) && (src_eq || dst_eq);
    end
  end

  always_comb begin
    case (req.op)
      OP_OPEN:  hit = hit_closed_r && open_ok;
      OP_ESTAB: hit = hit_syn_r;
      OP_FIN:   hit = hit_est_r || hit_fw_r;
      OP_OTHER: hit = hit_any_r;
      default:  hit = 1'b0;
    endcase
  end

  assign take              = hit && !chain_in.claimed;
  assign chain_out.claimed = chain_in.claimed || hit;
  assign chain_out.slot    = take ? idx : chain_in.slot;
  assign chain_out.closing = take ? (!hit_est_r && hit_fw_r) : chain_in.closing;
  assign open_o            = (state_r != ENT_CLOSED);

  always_comb begin
    state_nxt = state_r;
    if (commit_en && take) begin
      case (req.op)
        OP_OPEN:  state_nxt = ENT_SYN_WAIT;
        OP_ESTAB: state_nxt = ENT_ESTABLISHED;
        OP_FIN:   state_nxt = hit_est_r ? ENT_FIN_WAIT : ENT_CLOSED;
        default:  state_nxt = state_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENT_CLOSED;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_en && take && (req.op == OP_OPEN)) begin
      addr_r <= req.dst_ip;
      port_r <= req.dst_port;
      seq_r  <= req.seq_num;
    end
  end

endmodule

// ===== rtl/tcp_connection_limit_filter_unit.sv =====
`timescale 1ns / 1ps
// A request accepted at in_* is registered, matched into registered hit flags in each cell,
// then committed along the cell chain; its result is registered into out_*.
// A new request is taken in the commit cycle; a held result stalls commit and input.
// Reset (rst_n low at a clock edge): all table entries closed, open count zero,
// connection limit five, no result pending. No clearing pass is needed.

module tcp_connection_limit_filter_unit
  import tclf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_is_tcp,
  input  logic [31:0]      in_src_ip,
  input  logic [31:0]      in_dst_ip,
  input  logic [15:0]      in_src_port,
  input  logic [15:0]      in_dst_port,
  input  logic [31:0]      in_seq_num,
  input  logic [31:0]      in_ack_num,
  input  logic             in_syn_flag,
  input  logic             in_ack_flag,
  input  logic             in_fin_flag,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_pass,
  output logic [2:0]       out_event_res,
  output logic [2:0]       out_slot,
  output logic [3:0]       out_open_count
);

  st_t              state_r, state_nxt;
  req_t             req_r;
  op_t              op_dec;
  logic [LIM_W-1:0] limit_r;
  logic [CNT_W-1:0] open_total_r, open_total_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             pass_r, pass_nxt;
  ev_t              ev_r, ev_nxt;
  logic [2:0]       slot_r, slot_nxt;
  logic             accept, match_en, commit_go, open_ok;
  chain_t           chain [TABLE_ENTRIES+1];
  chain_t           last;
  logic [TABLE_ENTRIES-1:0] open_vec;

  always_comb begin
    if (!in_is_tcp) begin
      op_dec = OP_PASS;
    end else if (in_syn_flag && !in_ack_flag) begin
      op_dec = OP_OPEN;
    end else if (in_syn_flag) begin
      op_dec = OP_ESTAB;
    end else if (in_fin_flag) begin
      op_dec = OP_FIN;
    end else begin
      op_dec = OP_OTHER;
    end
  end

  always_comb begin
    state_nxt = state_r;
    match_en  = 1'b0;
    commit_go = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_MATCH: begin
        match_en  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || !out_stall) begin
          commit_go = 1'b1;
          in_stall  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    accept = in_valid && !in_stall;
    if (accept) begin
      state_nxt = S_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.op       <= op_dec;
      req_r.src_ip   <= in_src_ip;
      req_r.dst_ip   <= in_dst_ip;
      req_r.src_port <= in_src_port;
      req_r.dst_port <= in_dst_port;
      req_r.seq_num  <= in_seq_num;
      req_r.ack_num  <= in_ack_num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  assign open_ok  = 8'(open_total_r) < 8'(limit_r);
  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    tclf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (IDX_W'(i)),
      .req       (req_r),
      .match_en  (match_en),
      .commit_en (commit_go),
      .open_ok   (open_ok),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .open_o    (open_vec[i])
    );
  end

  assign last = chain[TABLE_ENTRIES];

  always_comb begin
    pass_nxt       = last.claimed;
    ev_nxt         = EV_NONE;
    slot_nxt       = 3'd0;
    open_total_nxt = open_total_r;
    case (req_r.op)
      OP_PASS: begin
        pass_nxt = 1'b1;
      end
      OP_OPEN: begin
        if (last.claimed) begin
          ev_nxt         = EV_OPENED;
          slot_nxt       = 3'(last.slot);
          open_total_nxt = open_total_r + CNT_W'(1);
        end
      end
      OP_ESTAB: begin
        if (last.claimed) begin
          ev_nxt   = EV_ESTABLISHED;
          slot_nxt = 3'(last.slot);
        end
      end
      OP_FIN: begin
        if (last.claimed) begin
          slot_nxt = 3'(last.slot);
          if (last.closing) begin
            ev_nxt = EV_CLOSED;
            if (open_total_r != '0) begin
              open_total_nxt = open_total_r - CNT_W'(1);
            end
          end else begin
            ev_nxt = EV_FIN;
          end
        end
      end
      default: begin
        ev_nxt = EV_NONE;
      end
    endcase
    out_valid_nxt = out_valid_r && out_stall;
    if (commit_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (commit_go) begin
        open_total_r <= open_total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      pass_r <= pass_nxt;
      ev_r   <= ev_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pass       = pass_r;
  assign out_event_res  = ev_r;
  assign out_slot       = slot_r;
  assign out_open_count = 4'(open_total_r);

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(open_vec) == int'(open_total_r))
    else $error("open count differs from cells in use");

  a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_MATCH)
    else $error("accepted request did not enter match");

  a_open_increments: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go && ev_nxt == EV_OPENED |=> open_total_r == $past(open_total_r) + CNT_W'(1))
    else $error("open did not advance the count");

  a_no_commit_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT && out_valid_r && out_stall |=> state_r == S_COMMIT)
    else $error("commit left while result was held");

endmodule
